// ===== design/slbs_pkg.sv =====
package slbs_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LED_MODE      = 3'd0;
    localparam logic [2:0] CFG_INVERT_OUTPUT = 3'd1;
    localparam logic [2:0] CFG_CUSTOM_ENABLE = 3'd2;
    localparam logic [2:0] CFG_CUSTOM_ON_MS  = 3'd3;
    localparam logic [2:0] CFG_CUSTOM_OFF_MS = 3'd4;

    // LED mode codes.
    localparam logic [1:0] MODE_OFF_READY  = 2'd0;
    localparam logic [1:0] MODE_ON_READY   = 2'd1;
    localparam logic [1:0] MODE_ALWAYS_OFF = 2'd2;

    // Device status codes.
    localparam logic [2:0] STAT_INIT        = 3'd0;
    localparam logic [2:0] STAT_NET_DOWN    = 3'd1;
    localparam logic [2:0] STAT_REGISTERING = 3'd2;
    localparam logic [2:0] STAT_READY       = 3'd3;
    localparam logic [2:0] STAT_CONFIG      = 3'd4;
    localparam logic [2:0] STAT_DOWNLOAD    = 3'd5;
    localparam logic [2:0] STAT_ERROR_A     = 3'd6;
    localparam logic [2:0] STAT_ERROR_B     = 3'd7;

    // Blink sequence codes reported on the output.
    localparam logic [2:0] SEQ_NET      = 3'd0;
    localparam logic [2:0] SEQ_SERVER   = 3'd1;
    localparam logic [2:0] SEQ_READY    = 3'd2;
    localparam logic [2:0] SEQ_CONFIG   = 3'd3;
    localparam logic [2:0] SEQ_DOWNLOAD = 3'd4;
    localparam logic [2:0] SEQ_ERROR    = 3'd5;
    localparam logic [2:0] SEQ_CUSTOM   = 3'd6;

    localparam int unsigned DUR_W     = 16;
    localparam int unsigned ELAPSED_W = 17;

    localparam logic [DUR_W-1:0] STEADY_MS = 16'd1000;

    // LED state; the unused code 3 behaves like not initialized.
    typedef enum logic [1:0] {
        LED_OFF    = 2'd0,
        LED_ON     = 2'd1,
        LED_UNINIT = 2'd2,
        LED_SPARE  = 2'd3
    } t_led_state;

    // Blink half-period of a mapped sequence; on and off times are equal.
    function automatic logic [DUR_W-1:0] map_duration(input logic [2:0] seq);
        logic [DUR_W-1:0] dur;
        unique case (seq)
            SEQ_NET:      dur = 16'd2000;
            SEQ_SERVER:   dur = 16'd500;
            SEQ_CONFIG:   dur = 16'd100;
            SEQ_DOWNLOAD: dur = 16'd20;
            default:      dur = 16'd500;
        endcase
        return dur;
    endfunction

endpackage

// ===== design/status_led_blink_sequencer_top.sv =====
// Channel     Dir  Handshake                          Payload
// ----------  ---  ---------------------------------  ------------------------------------
// s_axis      in   i_s_axis_tvalid / o_s_axis_tready  tdata[2:0] device_status
// m_axis      out  o_m_axis_tvalid / i_m_axis_tready  tdata[0] pin_level, [1] led_lit,
//                                                     [4:2] sequence_code
// cfg         in   i_cfg_we (no wait, no read-back)   i_cfg_addr index, i_cfg_wdata value
//
// One tick transaction per clock unless the output stalls: duration select,
// counter increment and the compare feed the state and result registers directly.
// A result is valid in the cycle after its tick is accepted.
// The result register is refilled in the cycle it is taken, so input is only
// stalled while a result waits and the output side is not ready.
// Reset clears the configuration, the elapsed counter and the output valid,
// and puts the LED into the not initialized state.
module status_led_blink_sequencer_top
    import slbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [2:0] device_status, [7:3] zero
    // Result output.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] pin_level, [1] led_lit,
                                          // [4:2] sequence_code, [7:5] zero
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    // Configuration registers.
    logic [1:0]       r_led_mode;
    logic             r_invert;
    logic             r_custom_en;
    logic [DUR_W-1:0] r_custom_on;
    logic [DUR_W-1:0] r_custom_off;

    // Blink state.
    t_led_state           r_led_state, n_led_state;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;

    // Result register.
    logic       r_out_valid;
    logic [4:0] r_out_data;

    logic                 w_accept;
    logic [2:0]           w_status;
    logic [2:0]           w_seq;
    logic [2:0]           w_map_seq;
    logic [DUR_W-1:0]     w_on_ms;
    logic [DUR_W-1:0]     w_off_ms;
    logic [ELAPSED_W-1:0] w_elapsed_inc;
    logic                 w_lit;

    assign w_status        = i_s_axis_tdata[2:0];
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Status to sequence code: init and net down share the net sequence.
    always_comb begin
        unique case (w_status) inside
            STAT_INIT, STAT_NET_DOWN:   w_map_seq = SEQ_NET;
            STAT_REGISTERING:           w_map_seq = SEQ_SERVER;
            STAT_READY:                 w_map_seq = SEQ_READY;
            STAT_CONFIG:                w_map_seq = SEQ_CONFIG;
            STAT_DOWNLOAD:              w_map_seq = SEQ_DOWNLOAD;
            STAT_ERROR_A, STAT_ERROR_B: w_map_seq = SEQ_ERROR;
            default:                    w_map_seq = SEQ_ERROR;
        endcase
    end

    // Duration select: always off wins over custom, custom over the map.
    always_comb begin
        if (r_led_mode == MODE_ALWAYS_OFF) begin
            w_seq    = SEQ_CUSTOM;
            w_on_ms  = '0;
            w_off_ms = STEADY_MS;
        end else if (r_custom_en) begin
            w_seq    = SEQ_CUSTOM;
            w_on_ms  = r_custom_on;
            w_off_ms = r_custom_off;
        end else if (w_map_seq == SEQ_READY) begin
            w_seq    = w_map_seq;
            w_on_ms  = (r_led_mode == MODE_ON_READY) ? STEADY_MS : '0;
            w_off_ms = (r_led_mode == MODE_ON_READY) ? '0 : STEADY_MS;
        end else begin
            w_seq    = w_map_seq;
            w_on_ms  = map_duration(w_map_seq);
            w_off_ms = map_duration(w_map_seq);
        end
    end

    // Saturating elapsed counter.
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    // Next LED state: steady handling for a zero duration, else phase timeout.
    always_comb begin
        n_led_state = r_led_state;
        n_elapsed   = w_elapsed_inc;
        if (w_on_ms == '0 || w_off_ms == '0) begin
            if (n_led_state != LED_OFF && w_on_ms == '0) begin
                n_led_state = LED_OFF;
                n_elapsed   = '0;
            end
            if (n_led_state != LED_ON && w_off_ms == '0) begin
                n_led_state = LED_ON;
                n_elapsed   = '0;
            end
        end else if (r_led_state == LED_ON && w_elapsed_inc > {1'b0, w_on_ms}) begin
            n_led_state = LED_OFF;
            n_elapsed   = '0;
        end else if (r_led_state == LED_OFF && w_elapsed_inc > {1'b0, w_off_ms}) begin
            n_led_state = LED_ON;
            n_elapsed   = '0;
        end
        // First tick: an LED still not initialized comes on, unless steady handling set it.
        if (n_led_state != LED_ON && n_led_state != LED_OFF) begin
            n_led_state = LED_ON;
            n_elapsed   = '0;
        end
    end

    assign w_lit = (n_led_state == LED_ON);

    // Configuration and blink state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_mode   <= MODE_OFF_READY;
            r_invert     <= 1'b0;
            r_custom_en  <= 1'b0;
            r_custom_on  <= '0;
            r_custom_off <= '0;
            r_led_state  <= LED_UNINIT;
            r_elapsed    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_LED_MODE:      r_led_mode   <= i_cfg_wdata[1:0];
                    CFG_INVERT_OUTPUT: r_invert     <= i_cfg_wdata[0];
                    CFG_CUSTOM_ENABLE: r_custom_en  <= i_cfg_wdata[0];
                    CFG_CUSTOM_ON_MS:  r_custom_on  <= i_cfg_wdata;
                    CFG_CUSTOM_OFF_MS: r_custom_off <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_led_state <= n_led_state;
                r_elapsed   <= n_elapsed;
            end
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {w_seq, w_lit, w_lit ^ r_invert};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_data};

    // After any tick the LED is in a defined on or off state.
    a_state_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_led_state == LED_ON || r_led_state == LED_OFF))
        else $error("LED state undefined after a tick");

    // The reported lit flag matches the state the tick left behind.
    a_lit_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_m_axis_tvalid && o_m_axis_tdata[1] == (r_led_state == LED_ON)))
        else $error("Reported lit flag disagrees with LED state");

    // Every toggle restarts the elapsed counter.
    a_toggle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_led_state != r_led_state) |=> (r_elapsed == '0))
        else $error("Elapsed counter not cleared on toggle");

    // A waiting, untaken result blocks new input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("Input accepted while result is stalled");

endmodule
